FILE: hw/rtl/sdf_pkg.sv
// Shared types and constants for the stream duplicate filter.
`timescale 1ns / 1ps
`default_nettype none
package sdf_pkg;

  // Width of the value field on both channels.
  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sdf_stream_if.sv
// Valid/ready channel interfaces for the request and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface sdf_req_if;
  logic            valid;
  logic            ready;
  sdf_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface sdf_res_if;
  logic            valid;
  logic            ready;
  sdf_pkg::value_t value_out;
  logic            keep;
  logic            store_full;
  logic            last_out;

  modport source (output valid, output value_out, output keep, output store_full,
                  output last_out, input ready);
  modport sink   (input valid, input value_out, input keep, input store_full,
                  input last_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/stream_duplicate_filter_top.sv
// Top level of the stream duplicate filter: cell chain, match reduction, result register.
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle unless out_chan stalls; all cells compare the incoming
// value in the same cycle; a new value enters the head while older ones shift down.
// Reset clears every cell valid bit and the result valid, so the store starts empty.
// The store also empties after each request that carries the last mark.
`timescale 1ns / 1ps
`default_nettype none
module stream_duplicate_filter_top #(
  parameter int unsigned MAX_DISTINCT = 64,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sdf_req_if.sink   in_chan,
  sdf_res_if.source out_chan
);

  // Only the low bits are compared; the port itself is never wider than the package width.
  localparam int unsigned CMP_W =
    (VALUE_WIDTH < sdf_pkg::VALUE_W) ? VALUE_WIDTH : sdf_pkg::VALUE_W;

  logic                    accept;
  logic [CMP_W-1:0]        probe;
  logic [MAX_DISTINCT-1:0] cell_valid;
  logic [MAX_DISTINCT-1:0] cell_match;
  logic [CMP_W-1:0]        cell_value [MAX_DISTINCT];
  logic                    seen;
  logic                    full;
  logic                    shift_en;
  logic                    clear;

  logic                    out_valid_r;
  sdf_pkg::value_t         value_out_r;
  logic                    keep_r;
  logic                    store_full_r;
  logic                    last_out_r;

  // Handshake: a new request enters whenever the result register is free or draining.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign probe         = in_chan.value[CMP_W-1:0];

  // Decision for the current request.
  assign seen     = |cell_match;
  assign full     = cell_valid[MAX_DISTINCT-1];
  assign shift_en = accept && !seen && !full;
  assign clear    = accept && in_chan.last;

  // Row of cells; the head takes the incoming value, each other cell its neighbor's.
  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    logic             prev_valid;
    logic [CMP_W-1:0] prev_value;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_value = probe;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_value = cell_value[i-1];
    end

    sdf_cell #(
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .clear      (clear),
      .prev_valid (prev_valid),
      .prev_value (prev_value),
      .probe      (probe),
      .valid_r    (cell_valid[i]),
      .value_r    (cell_value[i]),
      .match      (cell_match[i])
    );
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      value_out_r  <= in_chan.value;
      keep_r       <= !seen;
      store_full_r <= !seen && full;
      last_out_r   <= in_chan.last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.value_out  = value_out_r;
  assign out_chan.keep       = keep_r;
  assign out_chan.store_full = store_full_r;
  assign out_chan.last_out   = last_out_r;

  // The valid cells always form an unbroken run starting at the head.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + MAX_DISTINCT'(1))) == '0)
    else $error("cell valid bits are not a contiguous run from the head");

  // A request with the last mark leaves the store empty.
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.last |=> cell_valid == '0)
    else $error("store not empty after a last request");

  // A new value that fits lands in the head cell.
  a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en && !clear |=> cell_valid[0] && (cell_value[0] == $past(probe)))
    else $error("new value not inserted at the head cell");

  // A full indication is only ever given for a value that is kept.
  a_full_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && store_full_r |-> keep_r)
    else $error("store_full raised on a duplicate");

endmodule
`default_nettype wire

FILE: hw/rtl/sdf_cell.sv
// One storage cell of the seen-value chain: holds a value, compares, shifts on.
`timescale 1ns / 1ps
`default_nettype none
module sdf_cell #(
  parameter int unsigned CMP_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire logic             clear,
  input  wire logic             prev_valid,
  input  wire logic [CMP_W-1:0] prev_value,
  input  wire logic [CMP_W-1:0] probe,
  output logic                  valid_r,
  output logic [CMP_W-1:0]      value_r,
  output logic                  match
);

  // The cell matches when it holds a stored value equal to the probe.
  assign match = valid_r && (value_r == probe);

  // Valid bit: cleared at the end of a sequence, otherwise taken from the neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= prev_valid;
    end
  end

  // Stored value moves one cell down the chain on each insertion.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= prev_value;
    end
  end

endmodule
`default_nettype wire
